[rtl/core/ctg_pkg.sv]
// ----------------------------------------------------------------------------
// ctg_pkg
// Shared widths, register indexes, job record and the quarter-wave table
// for the circular trajectory generator.
// ----------------------------------------------------------------------------
package ctg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SINE_BITS       = 16;
    localparam int COUNT_BITS      = 24;

    localparam int QN         = 1 << TABLE_ADDR_BITS;
    localparam int MAG_BITS   = SINE_BITS + 1;
    localparam int AMP_BITS   = 31;
    localparam int PROD_BITS  = AMP_BITS + MAG_BITS;
    localparam int CMP_BITS   = COUNT_BITS + 1;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_AMP    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_COUNT = 3'd5;

    typedef logic [MAG_BITS-1:0] t_mag;
    typedef t_mag t_rom [0:QN];

    typedef struct packed {
        logic [1:0]                 quad;
        logic [TABLE_ADDR_BITS-1:0] idx;
        logic [23:0]                sample_index;
        logic [23:0]                turns_done;
        logic                       last;
    } t_job;

    // shift-subtract quotient, used only while building the table
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // quarter-wave magnitudes, Q30 taylor sum evaluated at elaboration
    function automatic t_rom build_rom();
        t_rom              rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   sum;
        longint unsigned   m;
        longint unsigned   div;
        longint unsigned   full;
        for (int k = 0; k <= QN; k++) begin
            full = 64'd1 << SINE_BITS;
            if (k == QN) begin
                m = full;
            end else begin
                x    = (64'd1686629713 * longint'(k)) >> TABLE_ADDR_BITS;
                x2   = (x * x) >> 30;
                sum  = x;
                term = x;
                for (int n = 1; n <= 8; n++) begin
                    div  = longint'((2 * n) * (2 * n + 1));
                    term = udiv64((term * x2) >> 30, div);
                    if (n[0]) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
                m = ((sum << SINE_BITS) + (64'd1 << 29)) >> 30;
                if (m > full) begin
                    m = full;
                end
            end
            rom[k] = MAG_BITS'(m);
        end
        return rom;
    endfunction

    localparam t_rom QUARTER_ROM = build_rom();

endpackage

[rtl/core/ctg_front.sv]
// ----------------------------------------------------------------------------
// ctg_front
// Tick intake: phase accumulator, sample and turn counters, run end.
// Emits one job per tick that yields a sample.
// ----------------------------------------------------------------------------
module ctg_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tick_valid,
    output logic                            o_tick_ready,
    input  logic                            i_restart,
    input  logic [31:0]                     i_phase_step,
    input  logic [23:0]                     i_sample_count,
    input  logic                            i_full,
    output logic                            o_push,
    output ctg_pkg::t_job                   o_job
);
    import ctg_pkg::*;

    logic [PHASE_BITS-1:0] r_phase;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] r_turns;
    logic                  r_fin;

    logic [PHASE_BITS-1:0] n_phase;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS-1:0] n_turns;
    logic                  n_fin;

    logic [PHASE_BITS-1:0] w_phase;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [COUNT_BITS-1:0] w_turns;
    logic                  w_fin;
    logic                  w_accept;
    logic                  w_last;
    logic [23:0]           w_count;
    logic [PHASE_BITS:0]   w_sum;

    assign o_tick_ready = !i_full;
    assign w_accept     = i_tick_valid && o_tick_ready;

    // restart clears the state before this tick's sample
    assign w_phase = i_restart ? '0 : r_phase;
    assign w_cnt   = i_restart ? '0 : r_cnt;
    assign w_turns = i_restart ? '0 : r_turns;
    assign w_fin   = i_restart ? 1'b0 : r_fin;

    assign w_count = (i_sample_count == '0) ? 24'd1 : i_sample_count;
    assign w_last  = (CMP_BITS'(w_cnt) + CMP_BITS'(1) >= CMP_BITS'(w_count))
                     || (w_cnt == '1);
    assign w_sum   = {1'b0, w_phase} + {1'b0, PHASE_BITS'(i_phase_step)};

    assign o_push            = w_accept && !w_fin;
    assign o_job.quad        = w_phase[PHASE_BITS-1 -: 2];
    assign o_job.idx         = w_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign o_job.sample_index = 24'(w_cnt);
    assign o_job.turns_done  = 24'(w_turns);
    assign o_job.last        = w_last;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_turns = r_turns;
        n_fin   = r_fin;
        if (o_push) begin
            n_phase = w_sum[PHASE_BITS-1:0];
            n_fin   = w_last;
            n_cnt   = w_last ? w_cnt : w_cnt + COUNT_BITS'(1);
            n_turns = (w_sum[PHASE_BITS] && w_turns != '1)
                      ? w_turns + COUNT_BITS'(1) : w_turns;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_cnt   <= '0;
            r_turns <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_turns <= n_turns;
            r_fin   <= n_fin;
        end
    end

    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.last) |=> (!o_push || i_restart))
        else $error("sample pushed after end of run without restart");

endmodule

[rtl/core/ctg_queue.sv]
// ----------------------------------------------------------------------------
// ctg_queue
// Short job queue between tick intake and sample datapath.
// ----------------------------------------------------------------------------
module ctg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ctg_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output ctg_pkg::t_job o_head
);
    import ctg_pkg::*;

    t_job                 r_mem [0:QDEPTH-1];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QCNT_BITS-1:0] r_count;

    assign o_full  = (r_count == QCNT_BITS'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_BITS'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_BITS'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> (!i_push || i_pop))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("job queue underflow");

endmodule

[rtl/core/ctg_back.sv]
// ----------------------------------------------------------------------------
// ctg_back
// Sample datapath: table lookup, amplitude products, rounding, center add
// and saturation into the output register.
// ----------------------------------------------------------------------------
module ctg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  ctg_pkg::t_job        i_head,
    output logic                 o_pop,
    input  logic signed [31:0]   i_center_x,
    input  logic signed [31:0]   i_center_y,
    input  logic [30:0]          i_radius,
    input  logic [30:0]          i_speed_amp,
    output logic                 o_smp_valid,
    input  logic                 i_smp_ready,
    output logic signed [31:0]   o_pos_x,
    output logic signed [31:0]   o_pos_y,
    output logic signed [31:0]   o_vel_x,
    output logic signed [31:0]   o_vel_y,
    output logic [23:0]          o_sample_index,
    output logic [23:0]          o_turns_done,
    output logic                 o_last
);
    import ctg_pkg::*;

    localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (SINE_BITS - 1);

    function automatic logic [30:0] round_mag(input logic [PROD_BITS-1:0] p);
        logic [PROD_BITS-1:0] s;
        s = p + HALF;
        return s[SINE_BITS +: 31];
    endfunction

    function automatic logic signed [33:0] apply_sign(input logic [30:0] m,
                                                      input logic neg);
        logic signed [33:0] t;
        t = {3'b000, m};
        return neg ? -t : t;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    logic en;

    logic                       r_s1_valid;
    t_mag                       r_s1_ms;
    t_mag                       r_s1_mc;
    logic                       r_s1_sneg;
    logic                       r_s1_cneg;
    t_job                       r_s1_job;

    logic                       r_s2_valid;
    logic [PROD_BITS-1:0]       r_s2_rc;
    logic [PROD_BITS-1:0]       r_s2_rs;
    logic [PROD_BITS-1:0]       r_s2_vs;
    logic [PROD_BITS-1:0]       r_s2_vc;
    logic                       r_s2_sneg;
    logic                       r_s2_cneg;
    t_job                       r_s2_job;

    logic                       r_out_valid;

    logic [TABLE_ADDR_BITS:0]   w_i;
    logic [TABLE_ADDR_BITS:0]   w_ni;
    logic [TABLE_ADDR_BITS:0]   w_sa;
    logic [TABLE_ADDR_BITS:0]   w_ca;

    assign en    = !r_out_valid || i_smp_ready;
    assign o_pop = en && !i_empty;

    assign w_i  = {1'b0, i_head.idx};
    assign w_ni = (TABLE_ADDR_BITS + 1)'(QN) - w_i;
    assign w_sa = i_head.quad[0] ? w_ni : w_i;
    assign w_ca = i_head.quad[0] ? w_i : w_ni;

    // lookup stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ms   <= QUARTER_ROM[w_sa];
            r_s1_mc   <= QUARTER_ROM[w_ca];
            r_s1_sneg <= i_head.quad[1];
            r_s1_cneg <= (i_head.quad == 2'd1) || (i_head.quad == 2'd2);
            r_s1_job  <= i_head;
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_rc   <= PROD_BITS'(i_radius) * PROD_BITS'(r_s1_mc);
            r_s2_rs   <= PROD_BITS'(i_radius) * PROD_BITS'(r_s1_ms);
            r_s2_vs   <= PROD_BITS'(i_speed_amp) * PROD_BITS'(r_s1_ms);
            r_s2_vc   <= PROD_BITS'(i_speed_amp) * PROD_BITS'(r_s1_mc);
            r_s2_sneg <= r_s1_sneg;
            r_s2_cneg <= r_s1_cneg;
            r_s2_job  <= r_s1_job;
        end
    end

    // rounding, center add and saturation
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_pos_x <= sat32(34'(i_center_x) + apply_sign(round_mag(r_s2_rc), r_s2_cneg));
            o_pos_y <= sat32(34'(i_center_y) + apply_sign(round_mag(r_s2_rs), r_s2_sneg));
            o_vel_x <= sat32(apply_sign(round_mag(r_s2_vs), !r_s2_sneg));
            o_vel_y <= sat32(apply_sign(round_mag(r_s2_vc), r_s2_cneg));
            o_sample_index <= r_s2_job.sample_index;
            o_turns_done   <= r_s2_job.turns_done;
            o_last         <= r_s2_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= o_pop;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    assign o_smp_valid = r_out_valid;

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && en) |=> r_out_valid)
        else $error("sample lost between product stage and output");

endmodule

[rtl/core/circular_trajectory_generator.sv]
// path: an accepted tick is queued as a job, then passes the lookup, product and output registers
// throughput: one tick per cycle, one sample per cycle while the job queue is not full and the
//   receiver takes samples; a tick after the end of a run gives no sample
// reset: synchronous, active low; registers return to defaults, phase and
//   counters clear, queue and pipeline empty; no clearing pass
// ----------------------------------------------------------------------------
// circular_trajectory_generator
// Quadrature oscillator that traces a circle, one position and velocity
// sample per tick up to the end of a run, with configuration registers.
// ----------------------------------------------------------------------------
module circular_trajectory_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ctg_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [ctg_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_tick_valid,
    output logic                                o_tick_ready,
    input  logic                                i_restart,
    output logic                                o_smp_valid,
    input  logic                                i_smp_ready,
    output logic signed [31:0]                  o_pos_x,
    output logic signed [31:0]                  o_pos_y,
    output logic signed [31:0]                  o_vel_x,
    output logic signed [31:0]                  o_vel_y,
    output logic [23:0]                         o_sample_index,
    output logic [23:0]                         o_turns_done,
    output logic                                o_last
);
    import ctg_pkg::*;

    logic [31:0]        r_phase_step;
    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic [30:0]        r_radius;
    logic [30:0]        r_speed_amp;
    logic [23:0]        r_sample_count;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_job;
    t_job w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= 32'd1;
            r_center_x     <= '0;
            r_center_y     <= '0;
            r_radius       <= 31'd65536;
            r_speed_amp    <= 31'd65536;
            r_sample_count <= 24'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PHASE_STEP:   r_phase_step   <= i_cfg_data;
                REG_CENTER_X:     r_center_x     <= i_cfg_data;
                REG_CENTER_Y:     r_center_y     <= i_cfg_data;
                REG_RADIUS:       r_radius       <= i_cfg_data[30:0];
                REG_SPEED_AMP:    r_speed_amp    <= i_cfg_data[30:0];
                REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    ctg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick_valid   (i_tick_valid),
        .o_tick_ready   (o_tick_ready),
        .i_restart      (i_restart),
        .i_phase_step   (r_phase_step),
        .i_sample_count (r_sample_count),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_job          (w_job)
    );

    ctg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    ctg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .i_center_x     (r_center_x),
        .i_center_y     (r_center_y),
        .i_radius       (r_radius),
        .i_speed_amp    (r_speed_amp),
        .o_smp_valid    (o_smp_valid),
        .i_smp_ready    (i_smp_ready),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_vel_x        (o_vel_x),
        .o_vel_y        (o_vel_y),
        .o_sample_index (o_sample_index),
        .o_turns_done   (o_turns_done),
        .o_last         (o_last)
    );

endmodule

[verif/tb_circular_trajectory_generator.sv]
// ----------------------------------------------------------------------------
// tb_circular_trajectory_generator
// Self-checking bench for the circular trajectory generator. Ticks go in
// through a valid/ready channel and samples come out through another one.
// An in-bench oscillator model keeps its own phase, counters and register
// copies and predicts each sample. Every sample the block delivers is
// compared field by field against the oldest prediction. The run starts
// with directed register settings and tick sequences, then moves through
// random settings, most of them with random idle gaps on both sides.
// ----------------------------------------------------------------------------
module tb_circular_trajectory_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import ctg_pkg::*;

    localparam int  SLOTS        = 1 << TABLE_ADDR_BITS;
    localparam int  SLOT_LO      = PHASE_BITS - 2 - TABLE_ADDR_BITS;
    localparam int  DRAIN_CYCLES = 12;
    localparam int  CYCLE_LIMIT  = 300000;
    localparam int  HOLD_CYCLES  = 60;
    localparam int  PHASES       = 12;
    localparam int  RUN_TICKS    = 100;
    localparam longint Q_MAX     = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_MIN     = -Q_MAX - 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [23:0] sample_index;
        logic [23:0] turns_done;
        logic        last;
    } t_osc_sample;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_we       = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_idx      = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
    logic                      tick_valid   = 1'b0;
    logic                      tick_ready;
    logic                      tick_restart = 1'b0;
    logic                      smp_valid;
    logic                      smp_ready    = 1'b0;
    logic signed [31:0]        pos_x;
    logic signed [31:0]        pos_y;
    logic signed [31:0]        vel_x;
    logic signed [31:0]        vel_y;
    logic [23:0]               sample_index;
    logic [23:0]               turns_done;
    logic                      last;

    // oscillator model state and register copies
    longint unsigned   wave_mag [0:SLOTS];
    logic [31:0]       cfg_step   = 32'd1;
    longint            cfg_cx     = 0;
    longint            cfg_cy     = 0;
    longint unsigned   cfg_radius = 65536;
    longint unsigned   cfg_amp    = 65536;
    logic [23:0]       cfg_count  = 24'd1;
    logic [31:0]       osc_phase  = '0;
    logic [23:0]       osc_count  = '0;
    logic [23:0]       osc_turns  = '0;
    bit                osc_done   = 1'b0;

    bit                tick_q [$];
    t_osc_sample       samples_due [$];
    t_osc_sample       due_now;
    bit                tick_busy         = 1'b0;
    int                sender_idle_pct   = 16;
    int                receiver_idle_pct = 79;
    bit                hold_req          = 1'b0;
    int                hold_left         = 0;
    int                fail_count        = 0;
    int                cycle_count       = 0;
    int                ticks_sent        = 0;
    int                samples_checked   = 0;
    int                runs_started      = 0;
    int                settings_used     = 0;

    circular_trajectory_generator i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_tick_valid   (tick_valid),
        .o_tick_ready   (tick_ready),
        .i_restart      (tick_restart),
        .o_smp_valid    (smp_valid),
        .i_smp_ready    (smp_ready),
        .o_pos_x        (pos_x),
        .o_pos_y        (pos_y),
        .o_vel_x        (vel_x),
        .o_vel_y        (vel_y),
        .o_sample_index (sample_index),
        .o_turns_done   (turns_done),
        .o_last         (last)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned taylor_quarter(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned m;
        if (k >= SLOTS) begin
            return 64'd1 << SINE_BITS;
        end
        x    = (64'd1686629713 * longint'(k)) >> TABLE_ADDR_BITS;
        x2   = (x * x) >> 30;
        acc  = x;
        term = x;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        m = ((acc << SINE_BITS) + (64'd1 << 29)) >> 30;
        if (m > (64'd1 << SINE_BITS)) begin
            m = 64'd1 << SINE_BITS;
        end
        return m;
    endfunction

    function automatic longint scale_mag(input longint unsigned amp,
                                         input longint unsigned mag, input bit neg);
        longint r;
        r = longint'((amp * mag + (64'd1 << (SINE_BITS - 1))) >> SINE_BITS);
        return neg ? -r : r;
    endfunction

    function automatic logic [31:0] clamp_q16(input longint v);
        if (v > Q_MAX) begin
            return 32'h7FFF_FFFF;
        end
        if (v < Q_MIN) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    task automatic predict_tick(input bit restart);
        logic [1:0]        quad;
        logic [9:0]        slot;
        longint unsigned   msin;
        longint unsigned   mcos;
        bit                sneg;
        bit                cneg;
        bit                is_last;
        logic [23:0]       eff;
        logic [32:0]       acc;
        t_osc_sample       s;
        if (restart) begin
            osc_phase = '0;
            osc_count = '0;
            osc_turns = '0;
            osc_done  = 1'b0;
        end
        if (osc_done) begin
            return;
        end
        quad = osc_phase[PHASE_BITS-1 -: 2];
        slot = osc_phase[SLOT_LO +: TABLE_ADDR_BITS];
        msin = quad[0] ? wave_mag[SLOTS - slot] : wave_mag[slot];
        mcos = quad[0] ? wave_mag[slot] : wave_mag[SLOTS - slot];
        sneg = (quad >= 2);
        cneg = (quad == 1) || (quad == 2);
        s.pos_x        = clamp_q16(cfg_cx + scale_mag(cfg_radius, mcos, cneg));
        s.pos_y        = clamp_q16(cfg_cy + scale_mag(cfg_radius, msin, sneg));
        s.vel_x        = clamp_q16(scale_mag(cfg_amp, msin, !sneg));
        s.vel_y        = clamp_q16(scale_mag(cfg_amp, mcos, cneg));
        s.sample_index = osc_count;
        s.turns_done   = osc_turns;
        eff            = (cfg_count == 0) ? 24'd1 : cfg_count;
        is_last        = ({1'b0, osc_count} + 25'd1 >= {1'b0, eff}) || (osc_count == '1);
        s.last         = is_last;
        samples_due.push_back(s);
        if (is_last) begin
            osc_done = 1'b1;
        end else begin
            osc_count = osc_count + 24'd1;
        end
        acc       = {1'b0, osc_phase} + {1'b0, cfg_step};
        osc_phase = acc[31:0];
        if (acc[32] && osc_turns != '1) begin
            osc_turns = osc_turns + 24'd1;
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // tick driver
    always @(negedge clk) begin
        if (!tick_busy) begin
            if (tick_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                tick_valid   <= 1'b1;
                tick_restart <= tick_q.pop_front();
                tick_busy    = 1'b1;
            end else begin
                tick_valid <= 1'b0;
            end
        end
    end

    // tick transfer
    always @(posedge clk) begin
        if (rst_n && tick_valid && tick_ready) begin
            predict_tick(tick_restart);
            tick_busy = 1'b0;
            ticks_sent++;
        end
    end

    // sample receiver, with long hold-off on request
    always @(negedge clk) begin
        if (hold_left > 0) begin
            smp_ready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            smp_ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end else begin
            smp_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // sample transfer check
    always @(posedge clk) begin
        if (rst_n && smp_valid && smp_ready) begin
            if (samples_due.size() == 0) begin
                $error("unexpected sample, index %0d", sample_index);
                fail_count++;
            end else begin
                due_now = samples_due.pop_front();
                check_field("pos_x", $signed(due_now.pos_x), pos_x);
                check_field("pos_y", $signed(due_now.pos_y), pos_y);
                check_field("vel_x", $signed(due_now.vel_x), vel_x);
                check_field("vel_y", $signed(due_now.vel_y), vel_y);
                check_field("sample_index", due_now.sample_index, sample_index);
                check_field("turns_done", due_now.turns_done, turns_done);
                check_field("last", due_now.last, last);
                samples_checked++;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_PHASE_STEP:   cfg_step   = data;
            REG_CENTER_X:     cfg_cx     = longint'(signed'(data));
            REG_CENTER_Y:     cfg_cy     = longint'(signed'(data));
            REG_RADIUS:       cfg_radius = {33'd0, data[30:0]};
            REG_SPEED_AMP:    cfg_amp    = {33'd0, data[30:0]};
            REG_SAMPLE_COUNT: cfg_count  = data[23:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (tick_q.size() > 0 || tick_busy || samples_due.size() > 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(4))
            0, 1:    return $urandom;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom_range(32'h0003_FFFF, 0);
        endcase
    endfunction

    task automatic random_setting(input bit long_run);
        logic [31:0] step;
        logic [31:0] count;
        case ($urandom_range(3))
            0:       step = $urandom;
            1:       step = $urandom_range(32'h000F_FFFF, 1);
            2:       step = 32'hFFFF_FFFF;
            default: step = 32'hC000_0000 | $urandom;
        endcase
        case ($urandom_range(8))
            0, 1, 2, 3, 4, 5: count = $urandom_range(40, 1);
            6:                count = 0;
            7:                count = $urandom_range(32'h00FF_FFFF, 41);
            default:          count = 32'h00FF_FFFF;
        endcase
        if (long_run) begin
            count = 32'h00FF_FFFF;
        end
        count = count | ($urandom & 32'hFF00_0000);
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_CENTER_X, pick_word());
        write_reg(REG_CENTER_Y, pick_word());
        write_reg(REG_RADIUS, pick_word());
        write_reg(REG_SPEED_AMP, pick_word());
        write_reg(REG_SAMPLE_COUNT, count);
        settings_used++;
    endtask

    // runs of ticks: mostly full runs, some cut short, some loose ticks
    task automatic queue_runs(input int want);
        int          got;
        int          len;
        int          cut;
        logic [23:0] eff;
        got = 0;
        eff = (cfg_count == 0) ? 24'd1 : cfg_count;
        while (got < want) begin
            len = (eff <= 64) ? int'(eff) : $urandom_range(64, 1);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5, 6: begin
                    tick_q.push_back(1'b1);
                    repeat (len - 1) tick_q.push_back(1'b0);
                    got += len;
                    if (eff <= 64 && $urandom_range(2) == 0) begin
                        repeat ($urandom_range(3, 1)) tick_q.push_back(1'b0);
                    end
                end
                7, 8: begin
                    cut = $urandom_range(len, 1);
                    tick_q.push_back(1'b1);
                    repeat (cut - 1) tick_q.push_back(1'b0);
                    got += cut;
                end
                default: begin
                    repeat ($urandom_range(5, 1)) tick_q.push_back($urandom_range(1, 0));
                end
            endcase
            runs_started++;
        end
    endtask

    initial begin
        for (int k = 0; k <= SLOTS; k++) begin
            wave_mag[k] = taylor_quarter(k);
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults: one sample per run
        tick_q = '{1'b0, 1'b0, 1'b1};
        drain();

        // quarter-turn steps, saturating center and magnitudes
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
        write_reg(REG_CENTER_Y, 32'h8000_0000);
        write_reg(REG_RADIUS, 32'hFFFF_FFFF);
        write_reg(REG_SPEED_AMP, 32'h7FFF_FFFF);
        write_reg(REG_SAMPLE_COUNT, 32'd10);
        tick_q.push_back(1'b1);
        repeat (10) tick_q.push_back(1'b0);
        drain();

        // zero count, zero radius and amplitude, phase step of all ones
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(REG_SAMPLE_COUNT, 32'd0);
        write_reg(REG_RADIUS, 32'd0);
        write_reg(REG_SPEED_AMP, 32'd0);
        write_reg(REG_CENTER_X, 32'hFFFF_0000);
        write_reg(REG_CENTER_Y, 32'h0001_0000);
        tick_q = '{1'b1, 1'b0, 1'b1};
        drain();

        // count lowered below the running index
        write_reg(REG_SAMPLE_COUNT, 32'd100);
        write_reg(REG_PHASE_STEP, 32'h1234_5679);
        write_reg(REG_RADIUS, 32'h0003_0000);
        write_reg(REG_SPEED_AMP, 32'h0001_8000);
        tick_q = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
        drain();
        write_reg(REG_SAMPLE_COUNT, 32'd3);
        tick_q = '{1'b0, 1'b0};
        drain();

        // unmapped indexes are ignored, zero step holds the phase
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
        write_reg(REG_PHASE_STEP, 32'd0);
        tick_q = '{1'b1, 1'b0};
        drain();
        settings_used += 5;

        for (int p = 0; p < PHASES; p++) begin
            if (p < 4) begin
                sender_idle_pct   = 16;
                receiver_idle_pct = 79;
            end else if (p < 8) begin
                sender_idle_pct   = 79;
                receiver_idle_pct = 16;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            random_setting(p == 8);
            if (p == 8) begin
                queue_runs(RUN_TICKS);
                hold_req = 1'b1;
            end else if (p == 9) begin
                queue_runs(RUN_TICKS / 2);
                drain();
                queue_runs(RUN_TICKS / 2);
            end else begin
                queue_runs(RUN_TICKS);
            end
            drain();
        end

        if (samples_due.size() != 0) begin
            $error("%0d samples never arrived", samples_due.size());
            fail_count++;
        end
        $display("run covered %0d ticks, %0d samples checked, %0d tick sequences",
                 ticks_sent, samples_checked, runs_started);
        $display("over %0d register settings with idle and stall mixes", settings_used);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
